// ===== rtl/cszp_pkg.sv =====
// ----------------------------------------------------------------------------
// cszp_pkg: shared types and constants for the strided 1D convolution
// Field widths, register indexes, reset values and the structs that travel
// between the sequencer, the shared MAC unit and the top level.
// ----------------------------------------------------------------------------
package cszp_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = 34;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Kernel storage
    localparam int NUM_COEFS    = 5;
    localparam int MAX_TAPS_DEF = 5;
    localparam int MAX_PAD      = 4;
    localparam int MAX_STEP     = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_3    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_4    = 3'd7;

    // Reset values
    localparam logic [2:0] TAP_COUNT_RST = 3'd3;
    localparam logic [2:0] STEP_SIZE_RST = 3'd1;
    localparam logic [2:0] PAD_WIDTH_RST = 3'd0;
    localparam logic signed [COEF_W-1:0] COEF_ONE_RST  = 16'sd4096;
    localparam logic signed [COEF_W-1:0] COEF_ZERO_RST = 16'sd0;

    typedef logic signed [COEF_W-1:0] coef_arr_t [NUM_COEFS];

    // Shape registers
    typedef struct packed {
        logic [2:0] tap_count;
        logic [2:0] step_size;
        logic [2:0] pad_width;
    } shape_cfg_t;

    // Commands to the shared MAC unit
    typedef struct packed {
        logic clr;
        logic mul_en;
    } mac_op_t;

    // Result word hand-off to the output register
    typedef struct packed {
        logic valid;
        logic final_word;
    } push_t;

endpackage

// ===== rtl/conv1d_stride_zero_pad.sv =====
// ----------------------------------------------------------------------------
// conv1d_stride_zero_pad: streaming strided 1D convolution with zero padding
// Usage:
//   s_axis: one signed 16-bit sample per word, tlast on the last sample of a
//   signal. m_axis: one 34-bit window sum (12 fraction bits) per word, tlast
//   on the last result produced by the word that closed the signal.
//   cfg: write tap count, stride, pad width and five Q3.12 coefficients
//   while the block is idle.
// Timing: one sample is worked on at a time. After the accept, every padded
//   position is taken in turn; every window that completes first hands the
//   held previous sum, if any, to the output register once it is free, then
//   walks its k taps (k = taps) through the shared multiplier one tap per
//   cycle and lets the last product settle; closing the word comes last. The
//   single MAC and its one-tap-per-cycle walk set the pace of the block.
// Reset: registers return to their defaults, the window empties and the next
//   sample starts a new signal.
// Stall: a result waits in the output register; the block keeps working and
//   takes new samples until it needs that register again.
// ----------------------------------------------------------------------------
module conv1d_stride_zero_pad
#(
    parameter int MAX_TAPS = cszp_pkg::MAX_TAPS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [cszp_pkg::S_TDATA_W-1:0]        s_axis_tdata,  // [15:0] sample
    input  logic                                  s_axis_tlast,  // end_of_signal
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [cszp_pkg::M_TDATA_W-1:0]        m_axis_tdata,  // [33:0] conv_value, zero fill
    output logic                                  m_axis_tlast,  // final_output
    // register writes
    input  logic                                  cfg_we,
    input  logic [cszp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cszp_pkg::CFG_DAT_W-1:0]        cfg_data
);

    cszp_pkg::shape_cfg_t              shape_reg;
    cszp_pkg::coef_arr_t               coef_reg;
    cszp_pkg::mac_op_t                 mac_op;
    cszp_pkg::push_t                   push;
    logic signed [cszp_pkg::COEF_W-1:0]   mac_coef;
    logic signed [cszp_pkg::SAMPLE_W-1:0] mac_smp;
    logic signed [cszp_pkg::ACC_W-1:0]    acc;
    logic                              slot_free;
    logic                              out_valid_reg;
    logic                              out_last_reg;
    logic signed [cszp_pkg::ACC_W-1:0] out_data_reg;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg.tap_count <= cszp_pkg::TAP_COUNT_RST;
            shape_reg.step_size <= cszp_pkg::STEP_SIZE_RST;
            shape_reg.pad_width <= cszp_pkg::PAD_WIDTH_RST;
            coef_reg[0] <= cszp_pkg::COEF_ONE_RST;
            coef_reg[1] <= cszp_pkg::COEF_ONE_RST;
            coef_reg[2] <= cszp_pkg::COEF_ONE_RST;
            coef_reg[3] <= cszp_pkg::COEF_ZERO_RST;
            coef_reg[4] <= cszp_pkg::COEF_ZERO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cszp_pkg::REG_TAP_COUNT: shape_reg.tap_count <= cfg_data[2:0];
                cszp_pkg::REG_STEP_SIZE: shape_reg.step_size <= cfg_data[2:0];
                cszp_pkg::REG_PAD_WIDTH: shape_reg.pad_width <= cfg_data[2:0];
                cszp_pkg::REG_COEF_0:    coef_reg[0] <= cfg_data;
                cszp_pkg::REG_COEF_1:    coef_reg[1] <= cfg_data;
                cszp_pkg::REG_COEF_2:    coef_reg[2] <= cfg_data;
                cszp_pkg::REG_COEF_3:    coef_reg[3] <= cfg_data;
                cszp_pkg::REG_COEF_4:    coef_reg[4] <= cfg_data;
                default:                 shape_reg <= shape_reg;
            endcase
        end
    end

    cszp_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .shape     (shape_reg),
        .coefs     (coef_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .mac_op    (mac_op),
        .mac_coef  (mac_coef),
        .mac_smp   (mac_smp),
        .slot_free (slot_free),
        .push      (push)
    );

    cszp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .coef  (mac_coef),
        .smp   (mac_smp),
        .acc   (acc)
    );

    // Output register
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_data_reg <= acc;
            out_last_reg <= push.final_word;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(cszp_pkg::M_TDATA_W - cszp_pkg::ACC_W){1'b0}}, out_data_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== rtl/cszp_mac.sv =====
// ----------------------------------------------------------------------------
// cszp_mac: shared multiply-accumulate unit
// One 16x16 signed multiply per cycle into a product register, accumulated
// in the next cycle into a 34-bit sum with 12 fraction bits.
// ----------------------------------------------------------------------------
module cszp_mac
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cszp_pkg::mac_op_t                       op,
    input  logic signed [cszp_pkg::COEF_W-1:0]      coef,
    input  logic signed [cszp_pkg::SAMPLE_W-1:0]    smp,
    output logic signed [cszp_pkg::ACC_W-1:0]       acc
);

    logic signed [cszp_pkg::PROD_W-1:0] prod_reg;
    logic signed [cszp_pkg::PROD_W-1:0] prod_next;
    logic                               prod_v_reg;
    logic signed [cszp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [cszp_pkg::ACC_W-1:0]  acc_next;

    // Product stage
    assign prod_next = coef * smp;

    // Accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (op.clr)
        begin
            acc_next = '0;
        end
        else if (prod_v_reg)
        begin
            acc_next = acc_reg + {{(cszp_pkg::ACC_W - cszp_pkg::PROD_W){prod_reg[cszp_pkg::PROD_W-1]}},
                                  prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            prod_v_reg <= op.mul_en;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/cszp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cszp_ctrl: sample window and take sequencer
// Walks one input word through its leading pad, sample and trailing pad
// takes, tracks fill count and stride phase, and drives the shared MAC one
// tap per cycle for every completed window.
// ----------------------------------------------------------------------------
module cszp_ctrl
#(
    parameter int MAX_TAPS = cszp_pkg::MAX_TAPS_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  cszp_pkg::shape_cfg_t                    shape,
    input  cszp_pkg::coef_arr_t                     coefs,
    // input word
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [cszp_pkg::SAMPLE_W-1:0]    in_sample,
    input  logic                                    in_last,
    // MAC unit
    output cszp_pkg::mac_op_t                       mac_op,
    output logic signed [cszp_pkg::COEF_W-1:0]      mac_coef,
    output logic signed [cszp_pkg::SAMPLE_W-1:0]    mac_smp,
    // output register
    input  logic                                    slot_free,
    output cszp_pkg::push_t                         push
);

    localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TAKE   = 3'd1;
    localparam logic [2:0] ST_PUSH   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_ACC    = 3'd4;
    localparam logic [2:0] ST_NEXT   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]                          state_reg, state_next;
    logic signed [cszp_pkg::SAMPLE_W-1:0] win_reg  [MAX_TAPS];
    logic signed [cszp_pkg::SAMPLE_W-1:0] win_next [MAX_TAPS];
    logic [3:0]                          fill_reg, fill_next;
    logic [1:0]                          phase_reg, phase_next;
    logic                                start_reg, start_next;
    logic signed [cszp_pkg::SAMPLE_W-1:0] smp_reg, smp_next;
    logic                                last_reg, last_next;
    logic [2:0]                          lead_reg, lead_next;
    logic [2:0]                          trail_reg, trail_next;
    logic                                spend_reg, spend_next;
    logic                                pend_reg, pend_next;
    logic [IW-1:0]                       j_reg, j_next;

    logic [2:0] tc_eff;
    logic [3:0] k_eff;
    logic [2:0] s_eff;
    logic [2:0] pad_eff;
    logic [4:0] j_ext;
    logic [4:0] widx;
    logic [2:0] p_inc;
    logic       more;
    logic signed [cszp_pkg::SAMPLE_W-1:0] take_val;

    // Effective shape: zero taps/step read as one, saturate at the limits
    always_comb
    begin
        tc_eff  = (shape.tap_count == 3'd0) ? 3'd1 : shape.tap_count;
        k_eff   = ({2'b00, tc_eff} > 5'(MAX_TAPS)) ? 4'(MAX_TAPS) : {1'b0, tc_eff};
        s_eff   = (shape.step_size == 3'd0) ? 3'd1 :
                  (shape.step_size > 3'(cszp_pkg::MAX_STEP)) ? 3'(cszp_pkg::MAX_STEP) :
                  shape.step_size;
        pad_eff = (shape.pad_width > 3'(cszp_pkg::MAX_PAD)) ? 3'(cszp_pkg::MAX_PAD) :
                  shape.pad_width;
    end

    // Tap operand select: coef j against window entry k-1-j
    always_comb
    begin
        j_ext    = 5'(j_reg);
        widx     = 5'(k_eff) - 5'd1 - j_ext;
        mac_smp  = win_reg[widx[IW-1:0]];
        mac_coef = (j_ext < 5'(cszp_pkg::NUM_COEFS)) ? coefs[j_ext[2:0]] : '0;
    end

    assign more     = (lead_reg != 3'd0) || spend_reg || (trail_reg != 3'd0);
    assign take_val = ((lead_reg == 3'd0) && spend_reg) ? smp_reg : '0;
    assign p_inc    = {1'b0, phase_reg} + 3'd1;
    assign in_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        start_next = start_reg;
        smp_next   = smp_reg;
        last_next  = last_reg;
        lead_next  = lead_reg;
        trail_next = trail_reg;
        spend_next = spend_reg;
        pend_next  = pend_reg;
        j_next     = j_reg;
        mac_op     = '0;
        push       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    smp_next   = in_sample;
                    last_next  = in_last;
                    lead_next  = start_reg ? pad_eff : 3'd0;
                    trail_next = in_last ? pad_eff : 3'd0;
                    spend_next = 1'b1;
                    start_next = 1'b0;
                    state_next = ST_TAKE;
                end
            end

            ST_TAKE:
            begin
                // consume one padded position
                if (lead_reg != 3'd0)
                begin
                    lead_next = lead_reg - 3'd1;
                end
                else if (spend_reg)
                begin
                    spend_next = 1'b0;
                end
                else
                begin
                    trail_next = trail_reg - 3'd1;
                end

                win_next[0] = take_val;
                for (int i = 1; i < MAX_TAPS; i++)
                begin
                    win_next[i] = win_reg[i-1];
                end

                fill_next  = (fill_reg != 4'd15) ? fill_reg + 4'd1 : fill_reg;
                state_next = ST_NEXT;
                if (fill_next == k_eff)
                begin
                    phase_next = 2'd0;
                    state_next = ST_PUSH;
                end
                else if (fill_next > k_eff)
                begin
                    if (p_inc >= s_eff)
                    begin
                        phase_next = 2'd0;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        phase_next = p_inc[1:0];
                    end
                end
                j_next = '0;
            end

            ST_PUSH:
            begin
                // a new window completes: the held sum is not the last one
                if (!pend_reg)
                begin
                    mac_op.clr = 1'b1;
                    state_next = ST_MUL;
                end
                else if (slot_free)
                begin
                    push.valid      = 1'b1;
                    push.final_word = 1'b0;
                    pend_next       = 1'b0;
                    mac_op.clr      = 1'b1;
                    state_next      = ST_MUL;
                end
            end

            ST_MUL:
            begin
                mac_op.mul_en = 1'b1;
                if (j_ext == 5'(k_eff) - 5'd1)
                begin
                    state_next = ST_ACC;
                end
                else
                begin
                    j_next = j_reg + IW'(1);
                end
            end

            ST_ACC:
            begin
                // last product lands in the sum this cycle
                pend_next  = 1'b1;
                state_next = ST_NEXT;
            end

            ST_NEXT:
            begin
                state_next = more ? ST_TAKE : ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!pend_reg || slot_free)
                begin
                    push.valid      = pend_reg;
                    push.final_word = last_reg;
                    pend_next       = 1'b0;
                    if (last_reg)
                    begin
                        fill_next  = 4'd0;
                        phase_next = 2'd0;
                        start_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= 4'd0;
            phase_reg <= 2'd0;
            start_reg <= 1'b1;
            lead_reg  <= 3'd0;
            trail_reg <= 3'd0;
            spend_reg <= 1'b0;
            pend_reg  <= 1'b0;
            j_reg     <= '0;
            for (int i = 0; i < MAX_TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            phase_reg <= phase_next;
            start_reg <= start_next;
            lead_reg  <= lead_next;
            trail_reg <= trail_next;
            spend_reg <= spend_next;
            pend_reg  <= pend_next;
            j_reg     <= j_next;
            win_reg   <= win_next;
        end
    end

    // Item payload
    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        last_reg <= last_next;
    end

endmodule

// ===== rtl/cszp_checker.sv =====
// ----------------------------------------------------------------------------
// cszp_checker: port-level checks for the strided convolution
// Watches the stream ports only; bound to the top level.
// ----------------------------------------------------------------------------
module cszp_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [cszp_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                               m_axis_tlast
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // One sample at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample accepted while previous one in work");

    // Sum never reaches the fill bits
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[cszp_pkg::M_TDATA_W-1:cszp_pkg::ACC_W] == '0))
        else $error("result fill bits not zero");

endmodule

bind conv1d_stride_zero_pad cszp_checker u_cszp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
